>>> rtl/core/bpc_pkg.sv
// Shared types and constants for the barometric compensation pipeline.
`timescale 1ns / 1ps

package bpc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEFF_W = 16;
  localparam int TEMP_W  = 19;
  localparam int PRESS_W = 18;
  localparam int WIDE_W  = 40;
  localparam int T2_W    = 18;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  // two items can be in the front stages when busy rises
  localparam logic [QCNT_W-1:0] QUEUE_BUSY_LVL = QCNT_W'(QUEUE_DEPTH - 3);

  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SENS        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TEMP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE  = 3'd5;

  localparam logic signed [TEMP_W-1:0] TEMP_REF  = 19'sd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_VLOW = -19'sd1500;
  localparam logic [PRESS_W-1:0]       PRESS_MAX = 18'd200000;

  typedef struct packed {
    logic [COEFF_W-1:0] sens;
    logic [COEFF_W-1:0] offset;
    logic [COEFF_W-1:0] sens_temp;
    logic [COEFF_W-1:0] offset_temp;
    logic [COEFF_W-1:0] ref_temp;
    logic [COEFF_W-1:0] temp_slope;
  } bpc_coeff_t;

  // first-order results plus the temperature class, handed to the back end
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp1;
    logic signed [WIDE_W-1:0] off1;
    logic signed [WIDE_W-1:0] sens1;
    logic [T2_W-1:0]          t2;
    logic                     low;
    logic                     vlow;
  } bpc_item_t;

  typedef struct packed {
    logic      valid;
    bpc_item_t item;
  } bpc_beat_t;

  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              empty;
  } bpc_qstat_t;

endpackage

>>> rtl/core/bpc_front.sv
// Front end: takes reading pairs, forms dT, first-order terms and the temperature class.
`timescale 1ns / 1ps

module bpc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [bpc_pkg::RAW_W-1:0]    raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]    raw_temperature,
  input  bpc_pkg::bpc_coeff_t          coeff,
  output bpc_pkg::bpc_beat_t           push
);

  logic                              v1_r;
  logic                              v2_r;
  logic [bpc_pkg::RAW_W-1:0]         d1_f1_r;
  logic [bpc_pkg::RAW_W-1:0]         d1_f2_r;
  logic signed [24:0]                dt_r;
  logic signed [24:0]                dt_nxt;
  logic signed [41:0]                pt_r;
  logic signed [41:0]                po_r;
  logic signed [41:0]                ps_r;
  logic signed [49:0]                sq_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp1;
  logic signed [bpc_pkg::WIDE_W-1:0] off1;
  logic signed [bpc_pkg::WIDE_W-1:0] sens1;

  assign dt_nxt = $signed({1'b0, raw_temperature}) - $signed({1'b0, coeff.ref_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      d1_f1_r <= raw_pressure;
      dt_r    <= dt_nxt;
    end
    if (v1_r) begin
      d1_f2_r <= d1_f1_r;
      pt_r    <= dt_r * $signed({1'b0, coeff.temp_slope});
      po_r    <= dt_r * $signed({1'b0, coeff.offset_temp});
      ps_r    <= dt_r * $signed({1'b0, coeff.sens_temp});
      sq_r    <= dt_r * dt_r;
    end
  end

  // arithmetic right shifts are plain part-selects of the signed products
  always_comb begin
    temp1 = bpc_pkg::TEMP_REF + $signed(pt_r[41:23]);
    off1  = $signed({8'd0, coeff.offset, 16'd0}) + $signed({{5{po_r[41]}}, po_r[41:7]});
    sens1 = $signed({9'd0, coeff.sens, 15'd0}) + $signed({{6{ps_r[41]}}, ps_r[41:8]});
    push.valid      = v2_r;
    push.item.d1    = d1_f2_r;
    push.item.temp1 = temp1;
    push.item.off1  = off1;
    push.item.sens1 = sens1;
    push.item.t2    = sq_r[48:31];
    push.item.low   = temp1 < bpc_pkg::TEMP_REF;
    push.item.vlow  = temp1 < bpc_pkg::TEMP_VLOW;
  end

endmodule

>>> rtl/core/bpc_queue.sv
// Short FIFO of classified items between the front and back ends.
`timescale 1ns / 1ps

module bpc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  bpc_pkg::bpc_beat_t  push,
  input  logic                pop,
  output bpc_pkg::bpc_item_t  head,
  output bpc_pkg::bpc_qstat_t stat
);

  bpc_pkg::bpc_item_t                mem_r [bpc_pkg::QUEUE_DEPTH];
  logic [bpc_pkg::QPTR_W-1:0]        wr_ptr_r;
  logic [bpc_pkg::QPTR_W-1:0]        rd_ptr_r;
  logic [bpc_pkg::QCNT_W-1:0]        count_r;
  logic [bpc_pkg::QCNT_W-1:0]        count_nxt;
  logic                              do_pop;

  assign do_pop = pop && (count_r != '0);

  always_comb begin
    count_nxt = count_r;
    if (push.valid && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push.valid && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push.valid) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  assign head       = mem_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.empty = (count_r == '0);

endmodule

>>> rtl/core/bpc_back.sv
// Back end: second-order corrections, pressure product and saturation.
`timescale 1ns / 1ps

module bpc_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  bpc_pkg::bpc_beat_t                in_beat,
  output logic                              res_valid,
  output logic signed [bpc_pkg::TEMP_W-1:0] res_temperature,
  output logic [bpc_pkg::PRESS_W-1:0]       res_pressure,
  output logic                              res_clipped
);

  logic [5:0] v_r;

  // stage 1: squares of the temperature distances
  logic [bpc_pkg::RAW_W-1:0]         d1_b1_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp1_b1_r;
  logic signed [bpc_pkg::WIDE_W-1:0] off1_b1_r;
  logic signed [bpc_pkg::WIDE_W-1:0] sens1_b1_r;
  logic [bpc_pkg::T2_W-1:0]          t2_b1_r;
  logic                              low_b1_r;
  logic                              vlow_b1_r;
  logic [35:0]                       f_r;
  logic [35:0]                       g_r;
  logic signed [19:0]                e_w;
  logic signed [19:0]                h_w;
  logic signed [39:0]                fsq;
  logic signed [39:0]                gsq;

  // stage 2: correction terms
  logic [bpc_pkg::RAW_W-1:0]         d1_b2_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp1_b2_r;
  logic signed [bpc_pkg::WIDE_W-1:0] off1_b2_r;
  logic signed [bpc_pkg::WIDE_W-1:0] sens1_b2_r;
  logic [bpc_pkg::T2_W-1:0]          t2_b2_r;
  logic [bpc_pkg::WIDE_W-1:0]        off2_r;
  logic [bpc_pkg::WIDE_W-1:0]        sens2_r;
  logic [bpc_pkg::WIDE_W-1:0]        f40;
  logic [bpc_pkg::WIDE_W-1:0]        g40;
  logic [bpc_pkg::WIDE_W-1:0]        five_f;
  logic [bpc_pkg::WIDE_W-1:0]        seven_g;
  logic [bpc_pkg::WIDE_W-1:0]        eleven_g;
  logic [bpc_pkg::WIDE_W-1:0]        off2_nxt;
  logic [bpc_pkg::WIDE_W-1:0]        sens2_nxt;

  // stage 3: corrected values
  logic [bpc_pkg::RAW_W-1:0]         d1_b3_r;
  logic signed [bpc_pkg::TEMP_W-1:0] temp_b3_r;
  logic signed [bpc_pkg::WIDE_W-1:0] off_b3_r;
  logic signed [bpc_pkg::WIDE_W-1:0] sens_b3_r;

  // stage 4: split pressure product
  logic signed [bpc_pkg::TEMP_W-1:0] temp_b4_r;
  logic signed [bpc_pkg::WIDE_W-1:0] off_b4_r;
  logic signed [44:0]                phi_r;
  logic [43:0]                       plo_r;

  // stage 5: product sum
  logic signed [bpc_pkg::TEMP_W-1:0] temp_b5_r;
  logic signed [bpc_pkg::WIDE_W-1:0] off_b5_r;
  logic signed [42:0]                q_r;
  logic signed [63:0]                prod;

  // stage 6: output register
  logic signed [43:0]                diff;
  logic signed [28:0]                p_w;
  logic [bpc_pkg::PRESS_W-1:0]       press_nxt;
  logic                              clip_nxt;
  logic signed [bpc_pkg::TEMP_W-1:0] temp_out_r;
  logic [bpc_pkg::PRESS_W-1:0]       press_out_r;
  logic                              clip_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], in_beat.valid};
    end
  end

  always_comb begin
    e_w = $signed({in_beat.item.temp1[bpc_pkg::TEMP_W-1], in_beat.item.temp1})
        - $signed({bpc_pkg::TEMP_REF[bpc_pkg::TEMP_W-1], bpc_pkg::TEMP_REF});
    h_w = $signed({in_beat.item.temp1[bpc_pkg::TEMP_W-1], in_beat.item.temp1})
        - $signed({bpc_pkg::TEMP_VLOW[bpc_pkg::TEMP_W-1], bpc_pkg::TEMP_VLOW});
    fsq = e_w * e_w;
    gsq = h_w * h_w;
  end

  always_comb begin
    f40      = {4'd0, f_r};
    g40      = {4'd0, g_r};
    five_f   = (f40 << 2) + f40;
    seven_g  = (g40 << 3) - g40;
    eleven_g = (g40 << 3) + (g40 << 1) + g40;
    off2_nxt  = '0;
    sens2_nxt = '0;
    if (low_b1_r) begin
      off2_nxt  = five_f >> 1;
      sens2_nxt = five_f >> 2;
      if (vlow_b1_r) begin
        off2_nxt  = (five_f >> 1) + seven_g;
        sens2_nxt = (five_f >> 2) + (eleven_g >> 1);
      end
    end
  end

  always_comb begin
    prod = $signed({phi_r[43:0], 20'd0}) + $signed({20'd0, plo_r});
    diff = $signed({q_r[42], q_r}) - $signed({{4{off_b5_r[bpc_pkg::WIDE_W-1]}}, off_b5_r});
    p_w  = diff[43:15];
    if (p_w[28]) begin
      press_nxt = '0;
      clip_nxt  = 1'b1;
    end else if (p_w > {11'd0, bpc_pkg::PRESS_MAX}) begin
      press_nxt = bpc_pkg::PRESS_MAX;
      clip_nxt  = 1'b1;
    end else begin
      press_nxt = p_w[bpc_pkg::PRESS_W-1:0];
      clip_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // B1
    d1_b1_r    <= in_beat.item.d1;
    temp1_b1_r <= in_beat.item.temp1;
    off1_b1_r  <= in_beat.item.off1;
    sens1_b1_r <= in_beat.item.sens1;
    t2_b1_r    <= in_beat.item.t2;
    low_b1_r   <= in_beat.item.low;
    vlow_b1_r  <= in_beat.item.vlow;
    f_r        <= fsq[35:0];
    g_r        <= gsq[35:0];
    // B2
    d1_b2_r    <= d1_b1_r;
    temp1_b2_r <= temp1_b1_r;
    off1_b2_r  <= off1_b1_r;
    sens1_b2_r <= sens1_b1_r;
    t2_b2_r    <= low_b1_r ? t2_b1_r : '0;
    off2_r     <= off2_nxt;
    sens2_r    <= sens2_nxt;
    // B3
    d1_b3_r    <= d1_b2_r;
    temp_b3_r  <= temp1_b2_r - $signed({1'b0, t2_b2_r});
    off_b3_r   <= off1_b2_r - $signed(off2_r);
    sens_b3_r  <= sens1_b2_r - $signed(sens2_r);
    // B4
    temp_b4_r  <= temp_b3_r;
    off_b4_r   <= off_b3_r;
    phi_r      <= $signed({1'b0, d1_b3_r}) * $signed(sens_b3_r[39:20]);
    plo_r      <= d1_b3_r * sens_b3_r[19:0];
    // B5
    temp_b5_r  <= temp_b4_r;
    off_b5_r   <= off_b4_r;
    q_r        <= prod[63:21];
    // B6
    temp_out_r  <= temp_b5_r;
    press_out_r <= press_nxt;
    clip_out_r  <= clip_nxt;
  end

  assign res_valid       = v_r[5];
  assign res_temperature = temp_out_r;
  assign res_pressure    = press_out_r;
  assign res_clipped     = clip_out_r;

endmodule

>>> rtl/core/baro_pressure_temp_compensation.sv
// Top level: calibration registers, front end, item queue and back end.
`timescale 1ns / 1ps

// Takes one raw pressure/temperature pair per clock while busy is low and returns the
// compensated temperature (0.01 C) and pressure (0.01 mbar, saturated, with a clip
// flag), strobed on out_valid for one cycle. Every cycle with busy low can carry a
// new pair; the depth comes from the multiplier stages (first-order products,
// correction squares, split 24x40 pressure product). The back end drains the queue
// every cycle, so busy stays low in normal use. The user must write calibration
// words through the cfg port only while no item is in flight; the block does not enforce it.

module baro_pressure_temp_compensation (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [bpc_pkg::RAW_W-1:0]           in_raw_pressure,
  input  logic [bpc_pkg::RAW_W-1:0]           in_raw_temperature,
  output logic                                out_valid,
  output logic signed [bpc_pkg::TEMP_W-1:0]   out_temperature_centi,
  output logic [bpc_pkg::PRESS_W-1:0]         out_pressure_centi,
  output logic                                out_pressure_clipped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::COEFF_W-1:0]         cfg_data
);

  bpc_pkg::bpc_coeff_t coeff_r;
  bpc_pkg::bpc_beat_t  push;
  bpc_pkg::bpc_beat_t  back_in;
  bpc_pkg::bpc_item_t  head;
  bpc_pkg::bpc_qstat_t qstat;
  logic                accept;
  logic                pop;

  assign cfg_ready = 1'b1;
  assign busy      = qstat.count > bpc_pkg::QUEUE_BUSY_LVL;
  assign accept    = start && !busy;
  assign pop       = !qstat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bpc_pkg::REG_SENS:        coeff_r.sens        <= cfg_data;
        bpc_pkg::REG_OFFSET:      coeff_r.offset      <= cfg_data;
        bpc_pkg::REG_SENS_TEMP:   coeff_r.sens_temp   <= cfg_data;
        bpc_pkg::REG_OFFSET_TEMP: coeff_r.offset_temp <= cfg_data;
        bpc_pkg::REG_REF_TEMP:    coeff_r.ref_temp    <= cfg_data;
        bpc_pkg::REG_TEMP_SLOPE:  coeff_r.temp_slope  <= cfg_data;
        default: ;
      endcase
    end
  end

  bpc_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .raw_pressure    (in_raw_pressure),
    .raw_temperature (in_raw_temperature),
    .coeff           (coeff_r),
    .push            (push)
  );

  bpc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (qstat)
  );

  assign back_in.valid = pop;
  assign back_in.item  = head;

  bpc_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_beat         (back_in),
    .res_valid       (out_valid),
    .res_temperature (out_temperature_centi),
    .res_pressure    (out_pressure_centi),
    .res_clipped     (out_pressure_clipped)
  );

  // every accepted beat comes out as a result strobe on out_valid
  a_latency_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##9 out_valid)
    else $error("accepted beat did not produce a result on time");

  a_latency_bwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, 9))
    else $error("result strobe without a matching accepted beat");

  a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push.valid && !pop && qstat.count == bpc_pkg::QCNT_W'(bpc_pkg::QUEUE_DEPTH)))
    else $error("item queue overflow");

  a_clip_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pressure_clipped) |->
      (out_pressure_centi == '0 || out_pressure_centi == bpc_pkg::PRESS_MAX))
    else $error("clipped pressure not at a range limit");

endmodule

>>> bench/baro_pressure_temp_compensation_tb.sv
// Self-checking testbench for the barometric compensation pipeline.
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_tb;
  import bpc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 14;
  localparam int REPORT_MAX  = 200;
  // indexes past the last register, writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic                     clip;
  } reading_t;

  class compensation_checker;
    longint   k_sens, k_off, k_sens_t, k_off_t, k_ref, k_slope;
    reading_t expected[$];
    int       fails;

    function new();
      k_sens = 0; k_off = 0; k_sens_t = 0; k_off_t = 0; k_ref = 0; k_slope = 0;
      fails = 0;
    endfunction

    function void note_config(logic [CFG_IDX_W-1:0] idx, logic [COEFF_W-1:0] val);
      case (idx)
        REG_SENS:        k_sens   = val;
        REG_OFFSET:      k_off    = val;
        REG_SENS_TEMP:   k_sens_t = val;
        REG_OFFSET_TEMP: k_off_t  = val;
        REG_REF_TEMP:    k_ref    = val;
        REG_TEMP_SLOPE:  k_slope  = val;
        default: ;
      endcase
    endfunction

    // second-order compensation of one reading pair
    function void note_reading(logic [RAW_W-1:0] raw_p, logic [RAW_W-1:0] raw_t);
      longint   d1, d2, dt, temp, off, sens, t2, f, g, off2, sens2, p;
      reading_t r;
      d1   = raw_p;
      d2   = raw_t;
      dt   = d2 - (k_ref <<< 8);
      temp = longint'(TEMP_REF) + ((dt * k_slope) >>> 23);
      off  = (k_off <<< 16) + ((k_off_t * dt) >>> 7);
      sens = (k_sens <<< 15) + ((k_sens_t * dt) >>> 8);
      if (temp < longint'(TEMP_REF)) begin
        t2    = (dt * dt) >>> 31;
        f     = (temp - longint'(TEMP_REF)) * (temp - longint'(TEMP_REF));
        off2  = (5 * f) >>> 1;
        sens2 = (5 * f) >>> 2;
        if (temp < longint'(TEMP_VLOW)) begin
          g     = (temp - longint'(TEMP_VLOW)) * (temp - longint'(TEMP_VLOW));
          off2  = off2 + 7 * g;
          sens2 = sens2 + ((11 * g) >>> 1);
        end
        temp = temp - t2;
        off  = off - off2;
        sens = sens - sens2;
      end
      p = (((d1 * sens) >>> 21) - off) >>> 15;
      r.temp = temp[TEMP_W-1:0];
      if (p < 0) begin
        r.press = '0;
        r.clip  = 1'b1;
      end else if (p > longint'(PRESS_MAX)) begin
        r.press = PRESS_MAX;
        r.clip  = 1'b1;
      end else begin
        r.press = p[PRESS_W-1:0];
        r.clip  = 1'b0;
      end
      expected.push_back(r);
    endfunction

    function void check_reading(logic signed [TEMP_W-1:0] t, logic [PRESS_W-1:0] p,
                                logic c);
      reading_t want;
      if (expected.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: unexpected result temp %0d press %0d clip %0b", $time, t, p, c);
        return;
      end
      want = expected.pop_front();
      if (t !== want.temp) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: temperature expected %0d got %0d", $time, want.temp, t);
      end
      if (p !== want.press) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: pressure expected %0d got %0d", $time, want.press, p);
      end
      if (c !== want.clip) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t: clip flag expected %0b got %0b", $time, want.clip, c);
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [RAW_W-1:0]         in_raw_pressure;
  logic [RAW_W-1:0]         in_raw_temperature;
  logic                     out_valid;
  logic signed [TEMP_W-1:0] out_temperature_centi;
  logic [PRESS_W-1:0]       out_pressure_centi;
  logic                     out_pressure_clipped;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index;
  logic [COEFF_W-1:0]       cfg_data;

  compensation_checker sb = new();
  logic [COEFF_W-1:0]  cur_ref = '0;
  int                  cycles = 0;

  baro_pressure_temp_compensation u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .start                 (start),
    .busy                  (busy),
    .in_raw_pressure       (in_raw_pressure),
    .in_raw_temperature    (in_raw_temperature),
    .out_valid             (out_valid),
    .out_temperature_centi (out_temperature_centi),
    .out_pressure_centi    (out_pressure_centi),
    .out_pressure_clipped  (out_pressure_clipped),
    .cfg_valid             (cfg_valid),
    .cfg_ready             (cfg_ready),
    .cfg_index             (cfg_index),
    .cfg_data              (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_reading(out_temperature_centi, out_pressure_centi, out_pressure_clipped);
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_item(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
    start              <= 1'b1;
    in_raw_pressure    <= raw_p;
    in_raw_temperature <= raw_t;
    do @(posedge clk); while (busy);
    sb.note_reading(raw_p, raw_t);
    @(negedge clk);
  endtask

  task automatic idle_gap(input int n);
    if (n > 0) begin
      start              <= 1'b0;
      in_raw_pressure    <= RAW_W'($urandom);
      in_raw_temperature <= RAW_W'($urandom);
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.note_config(idx, val);
    if (idx == REG_REF_TEMP)
      cur_ref = val;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [COEFF_W-1:0] s, input logic [COEFF_W-1:0] o,
                            input logic [COEFF_W-1:0] st, input logic [COEFF_W-1:0] ot,
                            input logic [COEFF_W-1:0] rt, input logic [COEFF_W-1:0] sl);
    write_reg(REG_SENS, s);
    write_reg(REG_OFFSET, o);
    write_reg(REG_SENS_TEMP, st);
    write_reg(REG_OFFSET_TEMP, ot);
    write_reg(REG_REF_TEMP, rt);
    write_reg(REG_TEMP_SLOPE, sl);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic wait_drain();
    idle_gap(1);
    while (sb.expected.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  function automatic logic [RAW_W-1:0] pick_temperature();
    case ($urandom_range(0, 9))
      0, 1, 2: return RAW_W'($urandom);
      3:       return $urandom_range(0, 1) ? '1 : '0;
      // around the reference point, where the normal and low temperature bands meet
      default: return {cur_ref, 8'h00} + RAW_W'($urandom_range(0, 1 << 22) - (1 << 21));
    endcase
  endfunction

  function automatic logic [RAW_W-1:0] pick_pressure();
    case ($urandom_range(0, 9))
      0, 1, 2: return RAW_W'($urandom);
      3:       return $urandom_range(0, 1) ? '1 : '0;
      default: return RAW_W'($urandom_range(24'h500000, 24'hB00000));
    endcase
  endfunction

  task automatic run_random(input int n, input bit no_gaps);
    int left;
    int burst;
    left = n;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && left > 0) begin
        send_item(pick_pressure(), pick_temperature());
        burst--;
        left--;
      end
      if (!no_gaps && $urandom_range(0, 3) != 0)
        idle_gap($urandom_range(1, 9));
    end
  endtask

  function automatic logic [COEFF_W-1:0] near_word(input logic [COEFF_W-1:0] w);
    return w + COEFF_W'($urandom_range(0, 8191) - 4096);
  endfunction

  initial begin
    rst_n              <= 1'b0;
    start              <= 1'b0;
    in_raw_pressure    <= '0;
    in_raw_temperature <= '0;
    cfg_valid          <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset calibration: all words zero
    send_item('0, '0);
    send_item('1, '1);
    send_item(24'h123456, 24'hA5C3F0);
    wait_drain();

    // typical factory calibration
    set_config(16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312);
    send_item(24'd9085466, 24'd8569150);
    send_item(24'd9085466, 24'd8566784);   // dT zero, exactly at the low band edge
    send_item(24'd9085466, 24'd8566783);   // just below 20 C
    send_item(24'd9085466, 24'd7529764);   // first-order temp exactly -15 C
    send_item(24'd9085466, 24'd7529763);   // just below -15 C
    send_item(24'd9085466, 24'd7466784);
    send_item(24'd9085466, '0);
    send_item(24'd9085466, '1);
    send_item('0, 24'd8569150);            // pressure clips low
    send_item('1, 24'd8569150);            // pressure clips high
    send_item('0, '0);
    send_item('1, '1);
    run_random(150, 1'b0);
    wait_drain();

    // writes to unused indexes must leave the calibration alone
    write_reg(IDX_UNUSED_LO, '1);
    write_reg(IDX_UNUSED_HI, '0);
    cfg_valid <= 1'b0;
    @(negedge clk);
    run_random(40, 1'b1);
    wait_drain();

    set_config('1, '1, '1, '1, '1, '1);
    send_item('0, '0);
    send_item('1, '1);
    send_item('1, '0);
    run_random(110, 1'b0);
    wait_drain();

    set_config('1, '0, '1, '0, '1, '0);
    run_random(100, 1'b0);
    wait_drain();

    for (int k = 0; k < 4; k++) begin
      if (k % 2 == 0)
        set_config(near_word(16'd40127), near_word(16'd36924), near_word(16'd23317),
                   near_word(16'd23282), near_word(16'd33464), near_word(16'd28312));
      else
        set_config(COEFF_W'($urandom), COEFF_W'($urandom), COEFF_W'($urandom),
                   COEFF_W'($urandom), COEFF_W'($urandom), COEFF_W'($urandom));
      run_random(160, k == 1);
      wait_drain();
    end

    if (sb.fails == 0 && sb.expected.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
